FILE: rtl/core/i2c_master_bit_engine_defines.svh
// ----------------------------------------------------------------------------
// I2C master bit engine - assertion macros
// Concurrent check helpers, clocked on i_clk and held off during reset.
// ----------------------------------------------------------------------------
`ifndef I2C_MASTER_BIT_ENGINE_DEFINES_SVH
`define I2C_MASTER_BIT_ENGINE_DEFINES_SVH
`ifndef SYNTHESIS
// property holds at every clock edge
`define I2CM_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("i2cm: check failed");
// pre at one edge implies post at the next edge
`define I2CM_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error("i2cm: check failed");
`else
`define I2CM_ASSERT(label, prop)
`define I2CM_ASSERT_NEXT(label, pre, post)
`endif
`endif

FILE: rtl/core/i2cm_pkg.sv
// ----------------------------------------------------------------------------
// I2C master bit engine - package
// Widths, command and register codes, and the word types shared by the block.
// ----------------------------------------------------------------------------
package i2cm_pkg;

    // tick counter width and its saturation value
    localparam int COUNT_WIDTH = 8;
    localparam int COUNT_MAX   = (1 << COUNT_WIDTH) - 1;

    localparam int PERIOD_W = 8;
    localparam int ADDR_W   = 7;
    localparam int WAIT_W   = (COUNT_WIDTH > PERIOD_W) ? COUNT_WIDTH : PERIOD_W;

    localparam int IN_DATA_W  = 16;
    localparam int IN_USER_W  = 3;
    localparam int OUT_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    // input mode codes
    localparam logic [2:0] MODE_TICK  = 3'd0;
    localparam logic [2:0] MODE_START = 3'd1;
    localparam logic [2:0] MODE_STOP  = 3'd2;
    localparam logic [2:0] MODE_WRITE = 3'd3;
    localparam logic [2:0] MODE_READ  = 3'd4;
    localparam logic [2:0] MODE_ADDR  = 3'd5;

    // running command (state of the sequencer)
    localparam logic [2:0] CMD_IDLE  = 3'd0;
    localparam logic [2:0] CMD_START = 3'd1;
    localparam logic [2:0] CMD_STOP  = 3'd2;
    localparam logic [2:0] CMD_WRITE = 3'd3;
    localparam logic [2:0] CMD_READ  = 3'd4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ADDRESS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ENABLE  = 2'd2;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 8'd30;

    typedef struct packed {
        logic [PERIOD_W-1:0] period_ticks;
        logic [ADDR_W-1:0]   target_addr;
        logic                bus_enabled;
    } t_cfg;

    typedef struct packed {
        logic [2:0] mode;
        logic [7:0] data_byte;
        logic       sda_in;
    } t_item;

    // first member is the top bit: scl_out lands in bit 0 of the word
    typedef struct packed {
        logic       refused;
        logic       done_res;
        logic       nack_seen;
        logic [7:0] read_data;
        logic       busy_res;
        logic       sda_out;
        logic       scl_out;
    } t_result;

endpackage

FILE: rtl/core/i2cm_cfg.sv
// ----------------------------------------------------------------------------
// I2C master bit engine - configuration registers
// Period, target address and bus enable, written by index.
// ----------------------------------------------------------------------------
module i2cm_cfg
    import i2cm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_wr_idx,
    input  logic [CFG_DATA_W-1:0] i_wr_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_wr_en) begin
            unique case (i_wr_idx)
                REG_PERIOD:  n_cfg.period_ticks = i_wr_data[PERIOD_W-1:0];
                REG_ADDRESS: n_cfg.target_addr  = i_wr_data[ADDR_W-1:0];
                REG_ENABLE:  n_cfg.bus_enabled  = i_wr_data[0];
                default:     n_cfg = r_cfg;     // unmapped index, ignored
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.period_ticks <= PERIOD_RESET;
            r_cfg.target_addr  <= '0;
            r_cfg.bus_enabled  <= 1'b0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: rtl/core/i2cm_core.sv
// ----------------------------------------------------------------------------
// I2C master bit engine - sequencer
// Holds the bus state and works out the next state and result for one word.
// ----------------------------------------------------------------------------
`include "i2c_master_bit_engine_defines.svh"

module i2cm_core
    import i2cm_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_go,
    input  t_item   i_item,
    input  t_cfg    i_cfg,
    output t_result o_result
);

    localparam logic [1:0] PH_0 = 2'd0;
    localparam logic [1:0] PH_1 = 2'd1;
    localparam logic [1:0] PH_2 = 2'd2;
    localparam logic [1:0] PH_3 = 2'd3;

    localparam logic [3:0] BIT_7    = 4'd7;
    localparam logic [3:0] BIT_LAST = 4'd8;

    logic [2:0]             r_cmd,   n_cmd;
    logic [1:0]             r_phase, n_phase;
    logic [COUNT_WIDTH-1:0] r_tick,  n_tick;
    logic [3:0]             r_bit,   n_bit;
    logic [7:0]             r_shift, n_shift;
    logic                   r_scl,   n_scl;
    logic                   r_sda,   n_sda;
    logic [7:0]             r_rx,    n_rx;
    logic                   r_nack,  n_nack;
    logic                   n_done;
    logic                   n_refused;

    logic                   w_is_cmd;
    logic                   w_send;
    logic [WAIT_W-1:0]      w_quarter;
    logic [WAIT_W-1:0]      w_half;
    logic [WAIT_W-1:0]      w_raw_wait;
    logic [WAIT_W-1:0]      w_wait;
    logic [COUNT_WIDTH:0]   w_next;
    logic                   w_wait_end;
    logic [7:0]             w_shift_adv;
    logic [7:0]             w_shift_rx;
    logic [3:0]             w_bit_inc;
    logic                   w_send_next;
    logic                   w_parked;

    assign w_is_cmd = (i_item.mode == MODE_START) || (i_item.mode == MODE_STOP) ||
                      (i_item.mode == MODE_WRITE) || (i_item.mode == MODE_READ) ||
                      (i_item.mode == MODE_ADDR);

    // write bits go out on bits 0..7, read answers its ACK on bit 8
    assign w_send = (r_cmd == CMD_WRITE) ? (r_bit < BIT_LAST) : (r_bit >= BIT_LAST);

    assign w_quarter = WAIT_W'(i_cfg.period_ticks >> 2);
    assign w_half    = WAIT_W'(i_cfg.period_ticks >> 1);

    always_comb begin
        if (r_cmd == CMD_START) begin
            w_raw_wait = (r_phase == PH_0) ? w_half : w_quarter;
        end else if (r_cmd == CMD_STOP) begin
            w_raw_wait = w_quarter;
        end else if (w_send) begin
            w_raw_wait = (r_phase == PH_1) ? w_half : w_quarter;
        end else begin
            w_raw_wait = w_quarter;
        end
    end

    // at least one tick, at most what the counter holds
    always_comb begin
        if (w_raw_wait == '0) begin
            w_wait = WAIT_W'(1);
        end else if (w_raw_wait > WAIT_W'(COUNT_MAX)) begin
            w_wait = WAIT_W'(COUNT_MAX);
        end else begin
            w_wait = w_raw_wait;
        end
    end

    assign w_next     = {1'b0, r_tick} + (COUNT_WIDTH + 1)'(1);
    assign w_wait_end = (WAIT_W + 1)'(w_next) >= (WAIT_W + 1)'(w_wait);

    assign w_shift_adv = ((r_cmd == CMD_WRITE) && (r_bit < BIT_LAST)) ?
                         {r_shift[6:0], 1'b0} : r_shift;
    assign w_shift_rx  = {r_shift[6:0], i_item.sda_in};
    assign w_bit_inc   = r_bit + 4'd1;
    assign w_send_next = (r_cmd == CMD_WRITE) ? (w_bit_inc < BIT_LAST)
                                              : (w_bit_inc >= BIT_LAST);

    always_comb begin
        logic l_bit_end;
        l_bit_end = 1'b0;
        n_cmd     = r_cmd;
        n_phase   = r_phase;
        n_tick    = r_tick;
        n_bit     = r_bit;
        n_shift   = r_shift;
        n_scl     = r_scl;
        n_sda     = r_sda;
        n_rx      = r_rx;
        n_nack    = r_nack;
        n_done    = 1'b0;
        n_refused = 1'b0;

        if (w_is_cmd) begin
            if ((r_cmd != CMD_IDLE) ||
                ((i_item.mode == MODE_START) && !i_cfg.bus_enabled)) begin
                n_refused = 1'b1;
            end else begin
                n_phase = PH_0;
                n_tick  = '0;
                n_bit   = '0;
                unique case (i_item.mode)
                    MODE_START: begin
                        n_cmd = CMD_START;
                        n_sda = 1'b0;
                    end
                    MODE_STOP: begin
                        n_cmd = CMD_STOP;
                        n_sda = 1'b0;
                    end
                    MODE_READ: begin
                        n_cmd   = CMD_READ;
                        n_shift = '0;
                    end
                    MODE_WRITE: begin
                        n_cmd   = CMD_WRITE;
                        n_shift = i_item.data_byte;
                        n_sda   = i_item.data_byte[7];
                    end
                    MODE_ADDR: begin
                        n_cmd   = CMD_WRITE;
                        n_shift = {i_cfg.target_addr, i_item.data_byte[0]};
                        n_sda   = i_cfg.target_addr[ADDR_W-1];
                    end
                    default: n_cmd = r_cmd;
                endcase
            end
        end else if (r_cmd != CMD_IDLE) begin
            if (!w_wait_end) begin
                n_tick = w_next[COUNT_WIDTH-1:0];
            end else begin
                n_tick = '0;
                if (r_cmd == CMD_START) begin
                    if (r_phase == PH_0) begin
                        n_scl   = 1'b0;
                        n_phase = PH_1;
                    end else begin
                        n_cmd   = CMD_IDLE;
                        n_phase = PH_0;
                        n_bit   = '0;
                        n_done  = 1'b1;
                    end
                end else if (r_cmd == CMD_STOP) begin
                    if (r_phase == PH_0) begin
                        n_scl   = 1'b1;
                        n_phase = PH_1;
                    end else begin
                        n_sda   = 1'b1;
                        n_cmd   = CMD_IDLE;
                        n_phase = PH_0;
                        n_bit   = '0;
                        n_done  = 1'b1;
                    end
                end else if (w_send) begin
                    case (r_phase)
                        PH_0: begin
                            n_scl   = 1'b1;
                            n_phase = PH_1;
                        end
                        PH_1: begin
                            n_scl   = 1'b0;
                            n_phase = PH_2;
                        end
                        default: l_bit_end = 1'b1;
                    endcase
                end else begin
                    case (r_phase)
                        PH_0: begin
                            n_scl   = 1'b1;
                            n_sda   = 1'b1;
                            n_phase = PH_1;
                        end
                        PH_1: begin
                            // sample point: data bit on read, ACK on write
                            if (r_cmd == CMD_READ) begin
                                n_shift = w_shift_rx;
                                if (r_bit == BIT_7) begin
                                    n_rx = w_shift_rx;
                                end
                            end else if (i_item.sda_in) begin
                                n_nack = 1'b1;
                            end
                            n_phase = PH_2;
                        end
                        PH_2: begin
                            n_scl   = 1'b0;
                            n_phase = PH_3;
                        end
                        default: l_bit_end = 1'b1;
                    endcase
                end

                if (l_bit_end) begin
                    n_shift = w_shift_adv;
                    n_phase = PH_0;
                    if (w_bit_inc > BIT_LAST) begin
                        n_cmd  = CMD_IDLE;
                        n_bit  = '0;
                        n_done = 1'b1;
                    end else begin
                        n_bit = w_bit_inc;
                        if (w_send_next) begin
                            n_sda = (r_cmd == CMD_WRITE) ? w_shift_adv[7] : 1'b0;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd   <= CMD_IDLE;
            r_phase <= PH_0;
            r_tick  <= '0;
            r_bit   <= '0;
            r_shift <= '0;
            r_scl   <= 1'b1;
            r_sda   <= 1'b1;
            r_rx    <= '0;
            r_nack  <= 1'b0;
        end else if (i_go) begin
            r_cmd   <= n_cmd;
            r_phase <= n_phase;
            r_tick  <= n_tick;
            r_bit   <= n_bit;
            r_shift <= n_shift;
            r_scl   <= n_scl;
            r_sda   <= n_sda;
            r_rx    <= n_rx;
            r_nack  <= n_nack;
        end
    end

    always_comb begin
        o_result.scl_out   = n_scl;
        o_result.sda_out   = n_sda;
        o_result.busy_res  = (n_cmd != CMD_IDLE);
        o_result.read_data = n_rx;
        o_result.nack_seen = n_nack;
        o_result.done_res  = n_done;
        o_result.refused   = n_refused;
    end

    assign w_parked = (r_phase == PH_0) && (r_tick == '0) && (r_bit == '0);

    // counters are parked whenever no command runs
    `I2CM_ASSERT(a_idle_parked, (r_cmd != CMD_IDLE) || w_parked)
    `I2CM_ASSERT(a_bit_range, r_bit <= BIT_LAST)
    `I2CM_ASSERT_NEXT(a_done_goes_idle, i_go && n_done, r_cmd == CMD_IDLE)

endmodule

FILE: rtl/core/i2c_master_bit_engine.sv
// ----------------------------------------------------------------------------
// I2C master bit engine - top level
// Tick-timed I2C master: start, stop, write, read and address byte commands.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  Signals                       Word contents (low bit up)
//  s_axis    in   tvalid/tready/tdata/tuser     tdata: data_byte, sda_in
//                                               tuser: mode
//  m_axis    out  tvalid/tready/tdata           scl_out, sda_out, busy_res,
//                                               read_data, nack_seen,
//                                               done_res, refused
//  cfg       in   i_cfg_valid/o_cfg_ready/      0 period_ticks, 1 target_addr,
//                 i_cfg_addr/i_cfg_data         2 bus_enabled; ready always high
//
//  Every input word yields exactly one result word, offered on m_axis once
//  it has passed the input register and then the result register.
//  A new word is taken every cycle while m_axis is not stalled; the whole
//  tick/command update is one pass of the sequencer logic.
//  Reset (synchronous, active low) releases SCL/SDA, empties both registers
//  and loads period_ticks = 30. A stalled m_axis holds the result register;
//  the input register then fills and s_axis_tready drops until it drains.
//
`include "i2c_master_bit_engine_defines.svh"

module i2c_master_bit_engine
    import i2cm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // [7:0] data_byte, [8] sda_in
    input  logic [IN_USER_W-1:0]  s_axis_tuser,   // [2:0] mode

    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,   // [0] scl_out, [1] sda_out,
                                                  // [2] busy_res, [10:3] read_data,
                                                  // [11] nack_seen, [12] done_res,
                                                  // [13] refused

    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg    w_cfg;
    t_result w_result;
    logic    w_advance;
    logic    w_s_accept;

    logic    r_in_valid;
    t_item   r_in_item;
    logic    r_out_valid;
    t_result r_out;

    // config registers: writes are never back-pressured
    assign o_cfg_ready = 1'b1;

    i2cm_cfg u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (i_cfg_valid),
        .i_wr_idx  (i_cfg_addr),
        .i_wr_data (i_cfg_data),
        .o_cfg     (w_cfg)
    );

    // the buffered word moves into the result register when that slot frees up
    assign w_advance     = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_advance;
    assign w_s_accept    = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_s_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    // input word register (payload, no reset)
    always_ff @(posedge i_clk) begin
        if (w_s_accept) begin
            r_in_item.mode      <= s_axis_tuser[2:0];
            r_in_item.data_byte <= s_axis_tdata[7:0];
            r_in_item.sda_in    <= s_axis_tdata[8];
        end
    end

    // sequencer: bus state steps once per advanced word
    i2cm_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_go     (w_advance),
        .i_item   (r_in_item),
        .i_cfg    (w_cfg),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // result word register (payload, no reset)
    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out <= w_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {(OUT_DATA_W - $bits(t_result))'(0), r_out};

    // a word may only land in a full input register if that register drains now
    `I2CM_ASSERT(a_no_overwrite, !(w_s_accept && r_in_valid) || w_advance)

endmodule

FILE: tb/i2c_master_bit_engine_tb.sv
// ----------------------------------------------------------------------------
// I2C master bit engine - testbench
// Drives tick and command words into the engine and keeps a cycle-free model
// of the SCL/SDA sequencer in step with every accepted word. Each result word
// is compared field by field with the model's prediction. A short directed
// plan covers refusals, unknown modes, ACK/NACK, all-ones and all-zeros
// reads, address byte masking and the extreme SCL periods. Random phases with
// fresh register settings then run whole bus transactions with stray words.
// ----------------------------------------------------------------------------
module i2c_master_bit_engine_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import i2cm_pkg::*;

    // modes outside the command set; the engine treats them as ticks
    localparam logic [2:0] MODE_SPARE_A = 3'd6;
    localparam logic [2:0] MODE_SPARE_B = 3'd7;

    localparam int RANDOM_WORDS = 1700;
    localparam int HOLD_CYCLES  = 300;       // receiver hold-off, fills the pipe
    localparam int DRAIN_WAIT   = 4;         // settle margin before a register write
    localparam int CYCLE_LIMIT  = 500000;
    localparam int MAX_REPORTS  = 40;

    localparam t_result IDLE_RES = '{refused: 1'b0, done_res: 1'b0, nack_seen: 1'b0,
                                     read_data: 8'h00, busy_res: 1'b0,
                                     sda_out: 1'b1, scl_out: 1'b1};
    localparam t_result REFUSED_RES = '{refused: 1'b1, done_res: 1'b0, nack_seen: 1'b0,
                                        read_data: 8'h00, busy_res: 1'b0,
                                        sda_out: 1'b1, scl_out: 1'b1};
    localparam t_item NO_WORD = '{mode: MODE_TICK, data_byte: 8'h00, sda_in: 1'b0};

    // ------------------------------------------------------------------------
    // DUT ports, every input known from time zero
    // ------------------------------------------------------------------------
    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;   // [7:0] data_byte, [8] sda_in
    logic [IN_USER_W-1:0]  s_axis_tuser = '0;   // [2:0] mode
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;        // t_result, scl_out in bit 0
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_addr = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    i2c_master_bit_engine dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Bus model: registers and sequencer state, reset values
    // ------------------------------------------------------------------------
    logic [7:0] period_cfg = PERIOD_RESET;
    logic [6:0] addr_cfg   = '0;
    logic       en_cfg     = 1'b0;

    logic [2:0] cmd_s   = CMD_IDLE;
    logic [2:0] phase_s = '0;
    logic [7:0] tick_s  = '0;
    logic [3:0] bit_s   = '0;
    logic [7:0] shift_s = '0;
    logic       scl_s   = 1'b1;
    logic       sda_s   = 1'b1;
    logic [7:0] rx_s    = '0;
    logic       nack_s  = 1'b0;

    t_result pending_q [$];      // predicted result words, oldest first

    int  words_sent    = 0;
    int  words_refused = 0;
    int  results_seen  = 0;
    int  bytes_read    = 0;
    int  settings_run  = 0;
    int  mismatches    = 0;
    int  cycle_count   = 0;
    int  send_idle_pct = 25;
    int  recv_idle_pct = 25;
    bit  hold_req      = 1'b0;

    // true while the current bit is driven by the master
    // (data bits of a write, ACK slot of a read)
    function automatic bit master_drives_bit();
        if (cmd_s == CMD_WRITE) return bit_s < 4'd8;
        return bit_s >= 4'd8;
    endfunction

    function automatic void open_bit();
        phase_s = '0;
        tick_s  = '0;
        if (master_drives_bit())
            sda_s = (cmd_s == CMD_WRITE) ? shift_s[7] : 1'b0;
    endfunction

    function automatic void close_cmd();
        cmd_s   = CMD_IDLE;
        phase_s = '0;
        tick_s  = '0;
        bit_s   = '0;
    endfunction

    // pin action at the end of a wait; returns 1 when the command completes
    function automatic bit wait_expired(logic sda_line);
        if (cmd_s == CMD_START) begin
            if (phase_s == 3'd0) begin
                scl_s   = 1'b0;
                phase_s = 3'd1;
                return 1'b0;
            end
            close_cmd();
            return 1'b1;
        end
        if (cmd_s == CMD_STOP) begin
            if (phase_s == 3'd0) begin
                scl_s   = 1'b1;
                phase_s = 3'd1;
                return 1'b0;
            end
            sda_s = 1'b1;
            close_cmd();
            return 1'b1;
        end
        if (master_drives_bit()) begin
            if (phase_s == 3'd0) begin
                scl_s   = 1'b1;
                phase_s = 3'd1;
                return 1'b0;
            end
            if (phase_s == 3'd1) begin
                scl_s   = 1'b0;
                phase_s = 3'd2;
                return 1'b0;
            end
        end else begin
            if (phase_s == 3'd0) begin
                scl_s   = 1'b1;
                sda_s   = 1'b1;
                phase_s = 3'd1;
                return 1'b0;
            end
            if (phase_s == 3'd1) begin
                if (cmd_s == CMD_READ) begin
                    shift_s = {shift_s[6:0], sda_line};
                    if (bit_s == 4'd7) begin
                        rx_s = shift_s;
                        bytes_read++;
                    end
                end else if (sda_line) begin
                    nack_s = 1'b1;       // sticky until reset
                end
                phase_s = 3'd2;
                return 1'b0;
            end
            if (phase_s == 3'd2) begin
                scl_s   = 1'b0;
                phase_s = 3'd3;
                return 1'b0;
            end
        end
        // bit slot finished
        if (cmd_s == CMD_WRITE && bit_s < 4'd8) shift_s = shift_s << 1;
        bit_s++;
        if (bit_s > 4'd8) begin
            close_cmd();
            return 1'b1;
        end
        open_bit();
        return 1'b0;
    endfunction

    // advances the model by one accepted word and returns its result word
    function automatic t_result bus_step(t_item w);
        int      quarter;
        int      half;
        int      span;
        bit      done;
        bit      deny;
        t_result r;
        quarter = int'(period_cfg) / 4;
        half    = int'(period_cfg) / 2;
        done    = 1'b0;
        deny    = 1'b0;
        if (w.mode >= MODE_START && w.mode <= MODE_ADDR) begin
            if (cmd_s != CMD_IDLE || (w.mode == MODE_START && !en_cfg)) begin
                deny = 1'b1;             // no time passes on a refused word
            end else begin
                phase_s = '0;
                tick_s  = '0;
                bit_s   = '0;
                case (w.mode)
                    MODE_START: begin
                        cmd_s = CMD_START;
                        sda_s = 1'b0;
                    end
                    MODE_STOP: begin
                        cmd_s = CMD_STOP;
                        sda_s = 1'b0;
                    end
                    MODE_READ: begin
                        cmd_s   = CMD_READ;
                        shift_s = '0;
                        open_bit();
                    end
                    default: begin
                        cmd_s   = CMD_WRITE;
                        shift_s = (w.mode == MODE_ADDR) ? {addr_cfg, w.data_byte[0]}
                                                        : w.data_byte;
                        open_bit();
                    end
                endcase
            end
        end else if (cmd_s != CMD_IDLE) begin
            if (cmd_s == CMD_START)      span = (phase_s == 3'd0) ? half : quarter;
            else if (cmd_s == CMD_STOP)  span = quarter;
            else if (master_drives_bit()) span = (phase_s == 3'd1) ? half : quarter;
            else                         span = quarter;
            if (span < 1) span = 1;
            if (span > COUNT_MAX) span = COUNT_MAX;
            if (int'(tick_s) + 1 >= span) begin
                tick_s = '0;
                done   = wait_expired(w.sda_in);
            end else begin
                tick_s = tick_s + 8'd1;
            end
        end
        r.scl_out   = scl_s;
        r.sda_out   = sda_s;
        r.busy_res  = (cmd_s != CMD_IDLE);
        r.read_data = rx_s;
        r.nack_seen = nack_s;
        r.done_res  = done;
        r.refused   = deny;
        return r;
    endfunction

    function automatic t_item mk_word(logic [2:0] mode, logic [7:0] data, logic sda);
        t_item w;
        w.mode      = mode;
        w.data_byte = data;
        w.sda_in    = sda;
        return w;
    endfunction

    // ------------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------------
    // offers one word, waits for acceptance, then records what it should yield;
    // a typed result, where given, replaces the model's prediction
    task automatic put_word(t_item w, bit typed, t_result typed_res);
        t_result pred;
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_DATA_W'({w.sda_in, w.data_byte});
        s_axis_tuser  <= w.mode;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        pred = bus_step(w);
        pending_q.push_back(typed ? typed_res : pred);
        if (pred.refused) words_refused++;
        else words_sent++;
    endtask

    // ticks until the running command completes; sda_sel 0/1 holds SDA at
    // that level, 2 randomizes it; noisy mixes in stray words while busy
    task automatic run_out(bit noisy, int sda_sel);
        logic [2:0] mode;
        logic       sda;
        while (cmd_s != CMD_IDLE) begin
            mode = MODE_TICK;
            if (noisy && $urandom_range(99) < 5) mode = 3'($urandom_range(7));
            sda = (sda_sel == 2) ? 1'($urandom_range(1)) : 1'(sda_sel);
            put_word(mk_word(mode, 8'($urandom_range(255)), sda), 1'b0, IDLE_RES);
        end
    endtask

    // register write, only with the engine drained
    task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
        s_axis_tvalid <= 1'b0;
        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        case (idx)
            REG_PERIOD:  period_cfg = val;
            REG_ADDRESS: addr_cfg   = val[6:0];
            REG_ENABLE:  en_cfg     = val[0];
            default: ;
        endcase
    endtask

    // start, address, a few data bytes, stop; slow periods keep to start/stop
    task automatic bus_transfer(bit slow);
        logic [2:0] mode;
        put_word(mk_word(MODE_START, 8'($urandom_range(255)), 1'($urandom_range(1))),
                 1'b0, IDLE_RES);
        run_out(1'b1, 2);
        if (!slow) begin
            put_word(mk_word(MODE_ADDR, 8'($urandom_range(255)), 1'($urandom_range(1))),
                     1'b0, IDLE_RES);
            run_out(1'b1, 2);
            repeat ($urandom_range(1, 3)) begin
                mode = $urandom_range(1) ? MODE_WRITE : MODE_READ;
                put_word(mk_word(mode, 8'($urandom_range(255)), 1'($urandom_range(1))),
                         1'b0, IDLE_RES);
                run_out(1'b1, 2);
            end
        end
        put_word(mk_word(MODE_STOP, 8'($urandom_range(255)), 1'($urandom_range(1))),
                 1'b0, IDLE_RES);
        run_out(1'b1, 2);
        // stray word on an idle bus, may open a command of its own
        if ($urandom_range(9) == 0) begin
            put_word(mk_word(3'($urandom_range(7)), 8'($urandom_range(255)),
                             1'($urandom_range(1))), 1'b0, IDLE_RES);
            run_out(1'b1, 2);
        end
    endtask

    // ------------------------------------------------------------------------
    // Output side: stall pattern, long hold-off on request
    // ------------------------------------------------------------------------
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    task automatic note_mismatch(string field, int unsigned want, int unsigned got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("%0t: result %0d %s mismatch, expected %0h actual %0h",
                     $time, results_seen, field, want, got);
    endtask

    t_result mon_got;
    t_result mon_want;

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            mon_got = t_result'(m_axis_tdata[$bits(t_result)-1:0]);
            if (pending_q.size() == 0) begin
                note_mismatch("unexpected word", 0, mon_got);
            end else begin
                mon_want = pending_q.pop_front();
                if (mon_got.scl_out !== mon_want.scl_out)
                    note_mismatch("scl_out", mon_want.scl_out, mon_got.scl_out);
                if (mon_got.sda_out !== mon_want.sda_out)
                    note_mismatch("sda_out", mon_want.sda_out, mon_got.sda_out);
                if (mon_got.busy_res !== mon_want.busy_res)
                    note_mismatch("busy_res", mon_want.busy_res, mon_got.busy_res);
                if (mon_got.read_data !== mon_want.read_data)
                    note_mismatch("read_data", mon_want.read_data, mon_got.read_data);
                if (mon_got.nack_seen !== mon_want.nack_seen)
                    note_mismatch("nack_seen", mon_want.nack_seen, mon_got.nack_seen);
                if (mon_got.done_res !== mon_want.done_res)
                    note_mismatch("done_res", mon_want.done_res, mon_got.done_res);
                if (mon_got.refused !== mon_want.refused)
                    note_mismatch("refused", mon_want.refused, mon_got.refused);
            end
            results_seen++;
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Directed plan: register writes and command words; each command is ticked
    // through to idle (settle) with SDA held at the row's level
    // ------------------------------------------------------------------------
    typedef struct packed {
        bit                   is_reg;
        logic [CFG_IDX_W-1:0] reg_idx;
        logic [7:0]           reg_val;
        t_item                w;
        bit                   settle;
        bit                   typed;
        t_result              typed_res;
    } t_row;

    localparam int PLAN_LEN = 26;

    t_row plan [PLAN_LEN] = '{
        // idle after reset, start refused while the bus is disabled
        '{1'b0, REG_PERIOD, 8'd0, '{MODE_TICK, 8'h00, 1'b0}, 1'b0, 1'b1, IDLE_RES},
        '{1'b0, REG_PERIOD, 8'd0, '{MODE_START, 8'hFF, 1'b1}, 1'b0, 1'b1, REFUSED_RES},
        // unknown modes act as ticks
        '{1'b0, REG_PERIOD, 8'd0, '{MODE_SPARE_A, 8'hFF, 1'b1}, 1'b0, 1'b1, IDLE_RES},
        '{1'b0, REG_PERIOD, 8'd0, '{MODE_SPARE_B, 8'h00, 1'b0}, 1'b0, 1'b1, IDLE_RES},
        // shortest legal period, address top bit ignored
        '{1'b1, REG_PERIOD, 8'd4, NO_WORD, 1'b0, 1'b0, IDLE_RES},
        '{1'b1, REG_ADDRESS, 8'hFF, NO_WORD, 1'b0, 1'b0, IDLE_RES},
        '{1'b1, REG_ENABLE, 8'h01, NO_WORD, 1'b0, 1'b0, IDLE_RES},
        // stop arrives while start is running: refused
        '{1'b0, REG_PERIOD, 8'd0, '{MODE_START, 8'h00, 1'b0}, 1'b0, 1'b0, IDLE_RES},
        '{1'b0, REG_PERIOD, 8'd0, '{MODE_STOP, 8'h00, 1'b0}, 1'b1, 1'b0, IDLE_RES},
        // read address, all-ones and all-zeros reads
        '{1'b0, REG_PERIOD, 8'd0, '{MODE_ADDR, 8'h01, 1'b0}, 1'b1, 1'b0, IDLE_RES},
        '{1'b0, REG_PERIOD, 8'd0, '{MODE_READ, 8'h00, 1'b1}, 1'b1, 1'b0, IDLE_RES},
        '{1'b0, REG_PERIOD, 8'd0, '{MODE_READ, 8'hFF, 1'b0}, 1'b1, 1'b0, IDLE_RES},
        // write with ACK, then with NACK (sticky flag)
        '{1'b0, REG_PERIOD, 8'd0, '{MODE_WRITE, 8'hFF, 1'b0}, 1'b1, 1'b0, IDLE_RES},
        '{1'b0, REG_PERIOD, 8'd0, '{MODE_WRITE, 8'h00, 1'b1}, 1'b1, 1'b0, IDLE_RES},
        // write address, upper data bits must not leak into the byte
        '{1'b0, REG_PERIOD, 8'd0, '{MODE_ADDR, 8'hFE, 1'b0}, 1'b1, 1'b0, IDLE_RES},
        '{1'b0, REG_PERIOD, 8'd0, '{MODE_STOP, 8'h00, 1'b0}, 1'b1, 1'b0, IDLE_RES},
        // period below four: quarter waits collapse to a single tick
        '{1'b1, REG_PERIOD, 8'd2, NO_WORD, 1'b0, 1'b0, IDLE_RES},
        '{1'b0, REG_PERIOD, 8'd0, '{MODE_START, 8'h00, 1'b0}, 1'b1, 1'b0, IDLE_RES},
        '{1'b0, REG_PERIOD, 8'd0, '{MODE_WRITE, 8'hA5, 1'b0}, 1'b1, 1'b0, IDLE_RES},
        '{1'b0, REG_PERIOD, 8'd0, '{MODE_STOP, 8'h00, 1'b1}, 1'b1, 1'b0, IDLE_RES},
        // longest period
        '{1'b1, REG_ADDRESS, 8'h00, NO_WORD, 1'b0, 1'b0, IDLE_RES},
        '{1'b1, REG_PERIOD, 8'd255, NO_WORD, 1'b0, 1'b0, IDLE_RES},
        '{1'b0, REG_PERIOD, 8'd0, '{MODE_START, 8'h00, 1'b0}, 1'b1, 1'b0, IDLE_RES},
        '{1'b0, REG_PERIOD, 8'd0, '{MODE_STOP, 8'h00, 1'b0}, 1'b1, 1'b0, IDLE_RES},
        // disabled again: start refused with state intact
        '{1'b1, REG_ENABLE, 8'h00, NO_WORD, 1'b0, 1'b0, IDLE_RES},
        '{1'b0, REG_PERIOD, 8'd0, '{MODE_START, 8'h00, 1'b0}, 1'b1, 1'b0, IDLE_RES}
    };

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        int  phase_no;
        int  target;
        int  pick;
        bit  slow;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < PLAN_LEN; i++) begin
            if (plan[i].is_reg) begin
                set_reg(plan[i].reg_idx, plan[i].reg_val);
            end else begin
                put_word(plan[i].w, plan[i].typed, plan[i].typed_res);
                if (plan[i].settle) run_out(1'b0, int'(plan[i].w.sda_in));
            end
        end

        // random phases: new settings, then whole transfers
        phase_no = 0;
        target   = words_sent + RANDOM_WORDS;
        while (words_sent < target) begin
            // the first two phases stay on short periods so both always run
            pick = (phase_no < 2) ? $urandom_range(69) : $urandom_range(99);
            slow = 1'b0;
            if (pick < 70) begin
                set_reg(REG_PERIOD, 8'($urandom_range(4, 10)));
            end else if (pick < 85) begin
                set_reg(REG_PERIOD, 8'($urandom_range(0, 3)));
            end else if (pick < 97) begin
                set_reg(REG_PERIOD, 8'($urandom_range(11, 40)));
            end else begin
                set_reg(REG_PERIOD, 8'd255);
                slow = 1'b1;
            end
            set_reg(REG_ADDRESS, 8'($urandom_range(255)));
            set_reg(REG_ENABLE, {7'($urandom_range(127)), 1'($urandom_range(9) != 0)});
            settings_run++;

            // second phase runs with no gaps on either side
            send_idle_pct = (phase_no == 1) ? 0 : 25;
            recv_idle_pct = (phase_no == 1) ? 0 : 25;
            // first phase: receiver stalls long while words keep coming
            if (phase_no == 0) hold_req = 1'b1;

            repeat ($urandom_range(1, 3)) bus_transfer(slow);
            phase_no++;
        end

        s_axis_tvalid <= 1'b0;
        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("tb: %0d words taken, %0d refused, %0d results checked",
                 words_sent, words_refused, results_seen);
        $display("tb: %0d random register settings, %0d bytes read, nack flag %0b",
                 settings_run, bytes_read, nack_s);
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/i2cm_pkg.sv
rtl/core/i2cm_cfg.sv
rtl/core/i2cm_core.sv
rtl/core/i2c_master_bit_engine.sv
tb/i2c_master_bit_engine_tb.sv
